### sv/srs_pkg.sv
package srs_pkg;

    localparam int MAX_STEPS_DEF = 256;
    localparam int CV_BITS_DEF   = 16;
    localparam int PULSE_W       = 16;
    localparam int POS_OUT_W     = 9;

    localparam logic [PULSE_W-1:0] PULSE_TICKS_RST = 16'd48;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REST,
        ST_NAV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic fire;
        logic cancel;
        logic run;
    } t_pulse_ctl;

    typedef struct packed {
        logic step_trigger;
        logic end_trigger;
        logic start_trigger;
        logic full_res;
    } t_res_flags;

endpackage

### sv/srs_if.sv
interface srs_sample_if #(
    parameter int CV_BITS = srs_pkg::CV_BITS_DEF
);
    logic                      valid;
    logic                      ready;
    logic signed [CV_BITS-1:0] cv_in;
    logic                      write_event;
    logic                      rest_event;
    logic                      clear_event;
    logic                      reset_event;
    logic                      forward_event;
    logic                      back_event;

    modport source (
        output valid, cv_in, write_event, rest_event, clear_event,
               reset_event, forward_event, back_event,
        input  ready
    );
    modport sink (
        input  valid, cv_in, write_event, rest_event, clear_event,
               reset_event, forward_event, back_event,
        output ready
    );
endinterface

interface srs_result_if #(
    parameter int CV_BITS = srs_pkg::CV_BITS_DEF
);
    logic                      valid;
    logic                      ready;
    logic signed [CV_BITS-1:0] cv_out;
    logic                      step_trigger;
    logic                      end_trigger;
    logic                      start_trigger;
    logic [8:0]                position;
    logic [8:0]                step_count;
    logic                      full_res;

    modport source (
        output valid, cv_out, step_trigger, end_trigger, start_trigger,
               position, step_count, full_res,
        input  ready
    );
    modport sink (
        input  valid, cv_out, step_trigger, end_trigger, start_trigger,
               position, step_count, full_res,
        output ready
    );
endinterface

interface srs_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [srs_pkg::PULSE_W-1:0] pulse_ticks;

    modport source (
        output valid, pulse_ticks,
        input  ready
    );
    modport sink (
        input  valid, pulse_ticks,
        output ready
    );
endinterface

### sv/srs_pulse.sv
module srs_pulse (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  srs_pkg::t_pulse_ctl         i_ctl,
    input  logic [srs_pkg::PULSE_W-1:0] i_ticks,
    output logic                        o_active
);
    import srs_pkg::*;

    logic [PULSE_W-1:0] r_left;
    logic [PULSE_W-1:0] n_left;

    assign o_active = (r_left != '0) && !i_ctl.cancel;

    always_comb begin
        n_left = r_left;
        if (i_ctl.fire) begin
            if (i_ticks > r_left) begin
                n_left = i_ticks;
            end
        end else if (i_ctl.run) begin
            if (i_ctl.cancel || r_left == '0) begin
                n_left = '0;
            end else begin
                n_left = r_left - PULSE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else begin
            r_left <= n_left;
        end
    end

endmodule

### sv/srs_core.sv
module srs_core #(
    parameter int MAX_STEPS = srs_pkg::MAX_STEPS_DEF,
    parameter int CV_BITS   = srs_pkg::CV_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    srs_sample_if.sink                    i_sample,
    input  logic [srs_pkg::PULSE_W-1:0]   i_pulse_ticks,
    input  logic                          i_res_ready,
    output logic                          o_res_valid,
    output logic [CV_BITS-1:0]            o_res_cv,
    output srs_pkg::t_res_flags           o_res_flags,
    output logic [srs_pkg::POS_OUT_W-1:0] o_res_pos,
    output logic [srs_pkg::POS_OUT_W-1:0] o_res_cnt
);
    import srs_pkg::*;

    localparam int IDX_W = $clog2(MAX_STEPS);
    localparam int CNT_W = $clog2(MAX_STEPS + 1);
    localparam int ENT_W = CV_BITS + 1;

    t_state r_state;
    t_state n_state;

    logic [ENT_W-1:0] step_mem [MAX_STEPS];
    logic [ENT_W-1:0] r_rd;
    logic             r_hit;

    logic [CNT_W-1:0] r_cursor;
    logic [CNT_W-1:0] r_length;
    logic [CNT_W-1:0] n_cursor;
    logic [CNT_W-1:0] n_length;

    logic r_rest;
    logic r_clear;
    logic r_reset;
    logic r_fwd;
    logic r_back;
    logic r_full;

    logic accept;
    logic idle_phase;
    logic rest_phase;
    logic nav_phase;
    logic done_phase;

    logic             st_en;
    logic [ENT_W-1:0] st_data;
    logic             at_end;
    logic             len_full;
    logic             st_full;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;

    logic nav_step;
    logic nav_end;
    logic nav_start;

    t_pulse_ctl step_ctl;
    t_pulse_ctl end_ctl;
    t_pulse_ctl start_ctl;
    logic       step_on;
    logic       end_on;
    logic       start_on;
    logic       rest_hit;

    logic [CNT_W+POS_OUT_W-1:0] pos_ext;
    logic [CNT_W+POS_OUT_W-1:0] cnt_ext;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_sample.valid) n_state = ST_REST;
            ST_REST: n_state = ST_NAV;
            ST_NAV:  n_state = ST_DONE;
            ST_DONE: if (i_res_ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // state decode
    always_comb begin
        idle_phase = 1'b0;
        rest_phase = 1'b0;
        nav_phase  = 1'b0;
        done_phase = 1'b0;
        case (r_state)
            ST_IDLE: idle_phase = 1'b1;
            ST_REST: rest_phase = 1'b1;
            ST_NAV:  nav_phase  = 1'b1;
            ST_DONE: done_phase = 1'b1;
            default: idle_phase = 1'b0;
        endcase
    end

    assign i_sample.ready = idle_phase;
    assign accept         = idle_phase && i_sample.valid;
    assign o_res_valid    = done_phase;

    // store path: write beat in idle, rest mark in the cycle after
    assign st_en    = (accept && i_sample.write_event) || (rest_phase && r_rest);
    assign st_data  = idle_phase ? {1'b0, i_sample.cv_in} : {1'b1, {CV_BITS{1'b0}}};
    assign at_end   = (r_cursor >= r_length);
    assign len_full = (r_length == CNT_W'(MAX_STEPS));
    assign st_full  = st_en && at_end && len_full;
    assign wr_en    = st_en && !st_full;
    assign wr_addr  = at_end ? r_length[IDX_W-1:0] : r_cursor[IDX_W-1:0];

    always_comb begin
        n_cursor  = r_cursor;
        n_length  = r_length;
        nav_step  = 1'b0;
        nav_end   = 1'b0;
        nav_start = 1'b0;
        if (wr_en) begin
            if (at_end) begin
                n_length = r_length + CNT_W'(1);
                n_cursor = r_length + CNT_W'(1);
            end else begin
                n_cursor = r_cursor + CNT_W'(1);
            end
        end
        if (nav_phase) begin
            if (r_clear) begin
                n_length = '0;
                n_cursor = '0;
            end
            if (r_reset) begin
                n_cursor  = '0;
                nav_start = 1'b1;
            end
            if (r_fwd && n_length != '0) begin
                n_cursor = n_cursor + CNT_W'(1);
                nav_step = 1'b1;
                if (n_cursor >= n_length) begin
                    n_cursor = '0;
                    nav_end  = 1'b1;
                end
            end
            if (r_back && n_length != '0) begin
                if (n_cursor == '0) begin
                    n_cursor = n_length - CNT_W'(1);
                end else begin
                    n_cursor = n_cursor - CNT_W'(1);
                end
                nav_step = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            step_mem[wr_addr] <= st_data;
        end
        if (nav_phase) begin
            r_rd <= step_mem[n_cursor[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cursor <= '0;
            r_length <= '0;
            r_rest   <= 1'b0;
            r_clear  <= 1'b0;
            r_reset  <= 1'b0;
            r_fwd    <= 1'b0;
            r_back   <= 1'b0;
            r_full   <= 1'b0;
            r_hit    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_length <= n_length;
            if (accept) begin
                r_rest  <= i_sample.rest_event;
                r_clear <= i_sample.clear_event;
                r_reset <= i_sample.reset_event;
                r_fwd   <= i_sample.forward_event;
                r_back  <= i_sample.back_event;
                r_full  <= st_full;
            end else if (rest_phase) begin
                r_full  <= r_full | st_full;
            end
            if (nav_phase) begin
                r_hit <= (n_cursor < n_length);
            end
        end
    end

    assign rest_hit = r_hit && r_rd[CV_BITS];

    assign step_ctl.fire    = wr_en || nav_step;
    assign step_ctl.cancel  = done_phase && rest_hit;
    assign step_ctl.run     = done_phase && i_res_ready;
    assign end_ctl.fire     = nav_end;
    assign end_ctl.cancel   = 1'b0;
    assign end_ctl.run      = done_phase && i_res_ready;
    assign start_ctl.fire   = nav_start;
    assign start_ctl.cancel = 1'b0;
    assign start_ctl.run    = done_phase && i_res_ready;

    srs_pulse u_step_pulse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (step_ctl),
        .i_ticks  (i_pulse_ticks),
        .o_active (step_on)
    );

    srs_pulse u_end_pulse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (end_ctl),
        .i_ticks  (i_pulse_ticks),
        .o_active (end_on)
    );

    srs_pulse u_start_pulse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (start_ctl),
        .i_ticks  (i_pulse_ticks),
        .o_active (start_on)
    );

    assign pos_ext = {{POS_OUT_W{1'b0}}, r_cursor};
    assign cnt_ext = {{POS_OUT_W{1'b0}}, r_length};

    assign o_res_cv                  = (r_hit && !r_rd[CV_BITS]) ? r_rd[CV_BITS-1:0] : '0;
    assign o_res_flags.step_trigger  = step_on;
    assign o_res_flags.end_trigger   = end_on;
    assign o_res_flags.start_trigger = start_on;
    assign o_res_flags.full_res      = r_full;
    assign o_res_pos                 = pos_ext[POS_OUT_W-1:0];
    assign o_res_cnt                 = cnt_ext[POS_OUT_W-1:0];

endmodule

### sv/step_recording_sequencer.sv
// step recording sequencer
// i_sample carries one sample tick per beat: the pitch sample and six event
// flags (write, rest, clear, reset, forward, back), applied in that order.
// o_result returns exactly one beat per input beat: the pitch of the step
// under the cursor, the three trigger pulses, position, step count and the
// full flag. i_cfg writes the trigger pulse length in ticks; write it only
// while no tick is in flight.
// each tick steps through the write store, the rest store, the cursor update
// with the step memory read, and the result; the single write port of the
// step memory keeps the write and rest stores apart. a new tick is taken only
// once the last result has gone to the output register.
// the result sits in an output register, so the next input beat is taken
// while a result waits; a stalled receiver holds the following tick in its
// result step until the output register frees up.
// synchronous reset empties the sequence, puts the cursor at zero, stops all
// pulses and sets the pulse length to 48 ticks. step memory contents are not
// cleared; entries are only used after they were written.
module step_recording_sequencer #(
    parameter int MAX_STEPS = srs_pkg::MAX_STEPS_DEF,
    parameter int CV_BITS   = srs_pkg::CV_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    srs_sample_if.sink    i_sample,
    srs_result_if.source  o_result,
    srs_cfg_if.sink       i_cfg
);
    import srs_pkg::*;

    logic [PULSE_W-1:0]   r_pulse_ticks;

    logic                 res_valid;
    logic                 res_ready;
    logic [CV_BITS-1:0]   res_cv;
    t_res_flags           res_flags;
    logic [POS_OUT_W-1:0] res_pos;
    logic [POS_OUT_W-1:0] res_cnt;

    logic                 r_out_valid;
    logic [CV_BITS-1:0]   r_out_cv;
    t_res_flags           r_out_flags;
    logic [POS_OUT_W-1:0] r_out_pos;
    logic [POS_OUT_W-1:0] r_out_cnt;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_ticks <= PULSE_TICKS_RST;
        end else if (i_cfg.valid) begin
            r_pulse_ticks <= i_cfg.pulse_ticks;
        end
    end

    srs_core #(
        .MAX_STEPS (MAX_STEPS),
        .CV_BITS   (CV_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_sample      (i_sample),
        .i_pulse_ticks (r_pulse_ticks),
        .i_res_ready   (res_ready),
        .o_res_valid   (res_valid),
        .o_res_cv      (res_cv),
        .o_res_flags   (res_flags),
        .o_res_pos     (res_pos),
        .o_res_cnt     (res_cnt)
    );

    assign res_ready = !r_out_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out_cv    <= res_cv;
            r_out_flags <= res_flags;
            r_out_pos   <= res_pos;
            r_out_cnt   <= res_cnt;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.cv_out        = r_out_cv;
    assign o_result.step_trigger  = r_out_flags.step_trigger;
    assign o_result.end_trigger   = r_out_flags.end_trigger;
    assign o_result.start_trigger = r_out_flags.start_trigger;
    assign o_result.position      = r_out_pos;
    assign o_result.step_count    = r_out_cnt;
    assign o_result.full_res      = r_out_flags.full_res;

endmodule

### tb/sv/step_recording_sequencer_tb.sv
`timescale 1ns / 100ps

module step_recording_sequencer_tb;
    import srs_pkg::*;

    localparam int DEPTH       = MAX_STEPS_DEF;
    localparam int CVW         = CV_BITS_DEF;
    localparam int HOLD_CYCLES = 160;
    localparam logic [CVW:0] REST_MARK = {1'b1, {CVW{1'b0}}};

    typedef struct packed {
        logic signed [CVW-1:0] cv;
        logic                  write_ev;
        logic                  rest_ev;
        logic                  clear_ev;
        logic                  reset_ev;
        logic                  fwd_ev;
        logic                  back_ev;
    } tick_t;

    typedef struct packed {
        logic signed [CVW-1:0]  cv;
        logic                   step_trig;
        logic                   end_trig;
        logic                   start_trig;
        logic [POS_OUT_W-1:0]   pos;
        logic [POS_OUT_W-1:0]   count;
        logic                   full;
    } step_res_t;

    logic i_clk     = 1'b0;
    logic i_rst_n   = 1'b0;
    logic took_tick = 1'b0;

    srs_sample_if #(.CV_BITS(CVW)) smp ();
    srs_result_if #(.CV_BITS(CVW)) res ();
    srs_cfg_if                     cfg ();

    step_recording_sequencer #(
        .MAX_STEPS(DEPTH),
        .CV_BITS  (CVW)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sample(smp),
        .o_result(res),
        .i_cfg   (cfg)
    );

    // sequencer shadow state
    logic [CVW:0]   step_mem [DEPTH];
    int unsigned    cur_pos;
    int unsigned    seq_len;
    logic [15:0]    tick_len;
    logic [15:0]    step_left;
    logic [15:0]    end_left;
    logic [15:0]    start_left;

    tick_t          pending_ticks [$];
    step_res_t      predicted_out [$];
    int             queued;
    int             in_beats;
    int             out_beats;
    int             mismatches;
    int             send_idle;
    int             recv_idle;
    int             hold_at;
    int             hold_taken;
    int             hold_left;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [15:0] pulse_load(input logic [15:0] left);
        return (tick_len > left) ? tick_len : left;
    endfunction

    // returns 1 when the append is dropped on a full memory
    function automatic bit store_step(input logic [CVW:0] entry);
        if (cur_pos >= seq_len) begin
            if (seq_len >= DEPTH) return 1'b1;
            step_mem[seq_len] = entry;
            seq_len++;
            cur_pos = seq_len;
        end else begin
            step_mem[cur_pos] = entry;
            cur_pos++;
        end
        step_left = pulse_load(step_left);
        return 1'b0;
    endfunction

    function automatic step_res_t sequence_tick(input tick_t t);
        step_res_t   r;
        logic [CVW:0] e;
        r = '0;
        if (t.write_ev) r.full |= store_step({1'b0, t.cv});
        if (t.rest_ev) r.full |= store_step(REST_MARK);
        if (t.clear_ev) begin
            seq_len = 0;
            cur_pos = 0;
        end
        if (t.reset_ev) begin
            cur_pos    = 0;
            start_left = pulse_load(start_left);
        end
        if (t.fwd_ev && seq_len != 0) begin
            cur_pos++;
            step_left = pulse_load(step_left);
            if (cur_pos >= seq_len) begin
                cur_pos  = 0;
                end_left = pulse_load(end_left);
            end
        end
        if (t.back_ev && seq_len != 0) begin
            cur_pos   = (cur_pos == 0) ? seq_len - 1 : cur_pos - 1;
            step_left = pulse_load(step_left);
        end
        if (cur_pos < seq_len) begin
            e = step_mem[cur_pos];
            if (e[CVW]) step_left = '0;
            else r.cv = e[CVW-1:0];
        end
        r.step_trig  = (step_left != 0);
        r.end_trig   = (end_left != 0);
        r.start_trig = (start_left != 0);
        if (step_left != 0) step_left--;
        if (end_left != 0) end_left--;
        if (start_left != 0) start_left--;
        r.pos   = cur_pos[POS_OUT_W-1:0];
        r.count = seq_len[POS_OUT_W-1:0];
        return r;
    endfunction

    function automatic void flag_field(input string field, input int want, input int got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s at result beat %0d: expected %0d, got %0d",
                         field, out_beats, want, got);
        end
    endfunction

    function automatic void check_result(input step_res_t want);
        flag_field("cv_out", int'(want.cv), int'(res.cv_out));
        flag_field("step_trigger", int'(want.step_trig), int'(res.step_trigger));
        flag_field("end_trigger", int'(want.end_trig), int'(res.end_trigger));
        flag_field("start_trigger", int'(want.start_trig), int'(res.start_trigger));
        flag_field("position", int'(want.pos), int'(res.position));
        flag_field("step_count", int'(want.count), int'(res.step_count));
        flag_field("full_res", int'(want.full), int'(res.full_res));
    endfunction

    // monitor: results are checked before the new beat is predicted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res.valid && res.ready) begin
                if (predicted_out.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result beat %0d arrived with nothing expected", out_beats);
                end else begin
                    check_result(predicted_out.pop_front());
                end
                out_beats++;
            end
            if (smp.valid && smp.ready) begin
                predicted_out.insert(predicted_out.size(),
                    sequence_tick(tick_t'{smp.cv_in, smp.write_event,
                    smp.rest_event, smp.clear_event, smp.reset_event,
                    smp.forward_event, smp.back_event}));
                in_beats++;
            end
            took_tick <= smp.valid && smp.ready;
        end else begin
            took_tick <= 1'b0;
        end
    end

    always @(negedge i_clk) begin : drive
        tick_t t;
        if (!i_rst_n) begin
            smp.valid <= 1'b0;
        end else if (!smp.valid || took_tick) begin
            if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle) begin
                t = pending_ticks.pop_front();
                smp.cv_in         <= t.cv;
                smp.write_event   <= t.write_ev;
                smp.rest_event    <= t.rest_ev;
                smp.clear_event   <= t.clear_ev;
                smp.reset_event   <= t.reset_ev;
                smp.forward_event <= t.fwd_ev;
                smp.back_event    <= t.back_ev;
                smp.valid         <= 1'b1;
            end else begin
                smp.valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off per marked phase
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            res.ready <= 1'b0;
        end else if (hold_at != 0 && in_beats >= hold_at && hold_taken != hold_at) begin
            hold_left  <= HOLD_CYCLES - 1;
            hold_taken <= hold_at;
            res.ready  <= 1'b0;
        end else begin
            res.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    function automatic bit chance(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic logic [CVW-1:0] rand_cv();
        case ($urandom_range(9))
            0:       return {1'b1, {(CVW-1){1'b0}}};
            1:       return {1'b0, {(CVW-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return CVW'($urandom_range(16'hFFFF));
        endcase
    endfunction

    function automatic tick_t make_tick(input logic [CVW-1:0] cv, input bit w, input bit r,
                                        input bit c, input bit z, input bit f, input bit b);
        return tick_t'{cv, w, r, c, z, f, b};
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        int    pick;
        int    w;
        t    = '0;
        t.cv = rand_cv();
        pick = $urandom_range(99);
        if (pick < 45) begin
            // recording
            w          = $urandom_range(99);
            t.write_ev = (w < 70);
            t.rest_ev  = (w >= 65 && w < 90);
            t.fwd_ev   = chance(5);
            t.back_ev  = chance(5);
            t.reset_ev = chance(3);
            t.clear_ev = chance(2);
        end else if (pick < 85) begin
            // playback
            t.fwd_ev   = chance(50);
            t.back_ev  = chance(20);
            t.write_ev = chance(10);
            t.rest_ev  = chance(5);
            t.reset_ev = chance(5);
            t.clear_ev = chance(2);
        end else begin
            t.write_ev = chance(50);
            t.rest_ev  = chance(50);
            t.clear_ev = chance(25);
            t.reset_ev = chance(50);
            t.fwd_ev   = chance(50);
            t.back_ev  = chance(50);
        end
        return t;
    endfunction

    task automatic push_tick(input tick_t t);
        pending_ticks.insert(pending_ticks.size(), t);
        queued++;
    endtask

    // wait for every queued beat to be answered, then let the block go quiet
    task automatic settle();
        do @(negedge i_clk); while (in_beats != queued || predicted_out.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_pulse_len(input logic [15:0] v);
        @(negedge i_clk);
        cfg.pulse_ticks <= v;
        cfg.valid       <= 1'b1;
        do @(posedge i_clk); while (!cfg.ready);
        tick_len = v;
        @(negedge i_clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic random_phase(input int n, input bit with_hold);
        @(posedge i_clk);
        if (with_hold) hold_at = queued + 40;
        repeat (n) push_tick(random_tick());
        settle();
    endtask

    // fill the memory to the top, then push appends into the full memory
    task automatic fill_phase();
        tick_t t;
        @(posedge i_clk);
        hold_at = queued + 60;
        push_tick(make_tick(rand_cv(), 0, 0, 1, 0, 0, 0));
        repeat (270) begin
            t          = '0;
            t.cv       = rand_cv();
            t.rest_ev  = chance(12);
            t.write_ev = !t.rest_ev || chance(50);
            push_tick(t);
        end
        push_tick(make_tick(rand_cv(), 0, 0, 0, 0, 1, 0));
        push_tick(make_tick(rand_cv(), 0, 0, 0, 0, 0, 1));
        push_tick(make_tick(rand_cv(), 1, 0, 0, 0, 0, 0));
        push_tick(make_tick(rand_cv(), 1, 1, 0, 0, 0, 0));
        push_tick(make_tick(rand_cv(), 0, 0, 0, 1, 0, 1));
        push_tick(make_tick(rand_cv(), 0, 1, 0, 0, 0, 0));
        push_tick(make_tick(rand_cv(), 0, 0, 0, 0, 0, 1));
        push_tick(make_tick(rand_cv(), 0, 0, 0, 0, 1, 0));
        settle();
    endtask

    initial begin : stim
        smp.valid         = 1'b0;
        smp.cv_in         = '0;
        smp.write_event   = 1'b0;
        smp.rest_event    = 1'b0;
        smp.clear_event   = 1'b0;
        smp.reset_event   = 1'b0;
        smp.forward_event = 1'b0;
        smp.back_event    = 1'b0;
        res.ready         = 1'b0;
        cfg.valid         = 1'b0;
        cfg.pulse_ticks   = '0;
        tick_len   = PULSE_TICKS_RST;
        step_left  = '0;
        end_left   = '0;
        start_left = '0;
        cur_pos    = 0;
        seq_len    = 0;
        queued     = 0;
        in_beats   = 0;
        out_beats  = 0;
        mismatches = 0;
        hold_at    = 0;
        hold_taken = 0;
        send_idle  = 8;
        recv_idle  = 79;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed ticks at the reset pulse length
        @(posedge i_clk);
        push_tick(make_tick(16'h0000, 0, 0, 0, 0, 0, 0));
        push_tick(make_tick(16'h1234, 0, 0, 0, 0, 1, 1));
        push_tick(make_tick(16'h8000, 1, 0, 0, 0, 0, 0));
        push_tick(make_tick(16'h7FFF, 1, 0, 0, 0, 0, 0));
        push_tick(make_tick(16'hABCD, 0, 1, 0, 0, 0, 0));
        push_tick(make_tick(16'h5555, 1, 0, 0, 0, 0, 0));
        push_tick(make_tick(16'hAAAA, 1, 1, 0, 0, 0, 0));
        push_tick(make_tick(16'h0000, 0, 0, 0, 0, 0, 1));
        push_tick(make_tick(16'h0000, 0, 0, 0, 0, 0, 1));
        push_tick(make_tick(16'h0000, 0, 0, 0, 0, 1, 0));
        push_tick(make_tick(16'h0000, 0, 0, 0, 0, 1, 0));
        push_tick(make_tick(16'h0000, 0, 0, 0, 0, 0, 1));
        push_tick(make_tick(16'h0000, 0, 0, 0, 1, 0, 0));
        push_tick(make_tick(16'hFFFF, 1, 0, 0, 0, 0, 0));
        push_tick(make_tick(16'h0001, 0, 1, 0, 0, 0, 0));
        push_tick(make_tick(16'h0000, 0, 0, 0, 0, 1, 1));
        push_tick(make_tick(16'h0000, 0, 0, 0, 1, 1, 0));
        push_tick(make_tick(16'h0000, 0, 0, 1, 0, 0, 0));
        push_tick(make_tick(16'h4321, 1, 0, 1, 0, 0, 0));
        push_tick(make_tick(16'h8001, 1, 1, 1, 1, 1, 1));
        push_tick(make_tick(16'h7FFE, 1, 0, 0, 0, 0, 0));
        push_tick(make_tick(16'h0000, 0, 0, 0, 0, 0, 0));
        settle();

        set_pulse_len(16'd1);
        random_phase(200, 1'b1);

        @(posedge i_clk);
        send_idle = 79;
        recv_idle = 8;
        set_pulse_len(16'd0);
        random_phase(150, 1'b0);
        set_pulse_len(16'hFFFF);
        fill_phase();

        @(posedge i_clk);
        send_idle = 0;
        recv_idle = 0;
        set_pulse_len(16'($urandom_range(60, 2)));
        random_phase(150, 1'b1);
        set_pulse_len(PULSE_TICKS_RST);
        random_phase(100, 1'b0);

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && predicted_out.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
